// ===== rtl/dfpa_pkg.sv =====
// ============================================================================
// dfpa_pkg
// Shared types and constants for the decimal fixed-point arithmetic unit.
// ============================================================================
`default_nettype none

package dfpa_pkg;

    // Scale of one unit: the magnitude holds value times 10^19
    localparam logic [63:0] DEC_ONE = 64'd10000000000000000000;

    localparam int WORD_W    = 128;
    localparam int MAG_W     = 127;
    localparam int LIMB_W    = 32;
    localparam int LIMBS     = WORD_W / LIMB_W;
    // Widest numerator: |a| * |b| < 2^254
    localparam int NUM_W     = 2 * MAG_W;
    localparam int DIV_STEPS = NUM_W;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_NEG = 3'd4,
        CMD_ABS = 3'd5
    } cmd_t;

    // Control that rides along the multiplier stages
    typedef struct packed {
        logic [2:0]        cmd;
        logic              sgn;
        logic              dz;
        logic [MAG_W-1:0]  d;
        logic [WORD_W-1:0] a;
    } ctl_t;

    // State of one item inside the divider array
    typedef struct packed {
        logic [MAG_W-1:0]  rem;
        logic [NUM_W-1:0]  nq;
        logic [MAG_W-1:0]  d;
        logic              use_q;
        logic              sgn;
        logic              dz;
        logic [WORD_W-1:0] alt;
    } div_pay_t;

endpackage

`default_nettype wire

// ===== rtl/decimal_fixed_point_alu.sv =====
// ============================================================================
// decimal_fixed_point_alu
// Pipelined add, sub, mul, div, neg and abs on 128-bit sign-magnitude
// decimal fixed-point numbers scaled by 10^19.
// ============================================================================
// The unit takes one item per clock unless the output stalls; each result passes
// through four multiplier stages (32x32 partial products and three levels of
// wide adds), 254 stages of a restoring divider array that retires one
// quotient bit per stage with one 128-bit compare-subtract, and the output
// register. Mul divides the full product by 10^19 and div divides |a| * 10^19
// by |b| in the same divider array. Add, sub, neg and abs are settled in the
// first stages and ride along. When the output is not taken, the whole
// pipeline holds; nothing is lost or repeated.
`default_nettype none

module decimal_fixed_point_alu
    import dfpa_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [63:0] a_upper, [127:64] a_lower, [191:128] b_upper, [255:192] b_lower
    input  wire logic [255:0]  s_axis_tdata,
    // [2:0] cmd
    input  wire logic [2:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [63:0] res_upper, [127:64] res_lower
    output logic [127:0]       m_axis_tdata,
    // [0] divide_by_zero
    output logic [0:0]         m_axis_tuser
);

    logic en;

    // Advance everything unless the output holds an untaken item
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 1: partial products, operand negation ----------
    logic [WORD_W-1:0] am, bm, y_op;
    logic [63:0]       pp_next [LIMBS][LIMBS];
    logic [63:0]       pp_reg  [LIMBS][LIMBS];
    logic [WORD_W-1:0] ta_next, tb_next, ta_reg, tb_reg;
    ctl_t              c1_next, c1_reg;
    logic              s1_valid_reg;
    logic              sa, sb;

    always_comb
    begin
        am   = {1'b0, s_axis_tdata[62:0], s_axis_tdata[127:64]};
        bm   = {1'b0, s_axis_tdata[190:128], s_axis_tdata[255:192]};
        sa   = s_axis_tdata[63];
        sb   = s_axis_tdata[191];
        y_op = (s_axis_tuser == CMD_DIV) ? {64'd0, DEC_ONE} : bm;
        for (int i = 0; i < LIMBS; i++)
        begin
            for (int j = 0; j < LIMBS; j++)
            begin
                pp_next[i][j] = am[i*LIMB_W +: LIMB_W] * y_op[j*LIMB_W +: LIMB_W];
            end
        end
        ta_next = sa ? (~am + 128'd1) : am;
        tb_next = (sb ^ (s_axis_tuser == CMD_SUB)) ? (~bm + 128'd1) : bm;
        c1_next.cmd = s_axis_tuser;
        c1_next.sgn = sa ^ sb;
        c1_next.dz  = (s_axis_tuser == CMD_DIV) && (bm == '0);
        c1_next.d   = (s_axis_tuser == CMD_DIV) ? bm[MAG_W-1:0]
                                                : {63'd0, DEC_ONE};
        c1_next.a   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg <= pp_next;
            ta_reg <= ta_next;
            tb_reg <= tb_next;
            c1_reg <= c1_next;
        end
    end

    // ---------------- stage 2: pair partial products, add/sub sum ---------
    logic [96:0]       h_next [LIMBS][2];
    logic [96:0]       h_reg  [LIMBS][2];
    logic [WORD_W-1:0] sum_reg;
    ctl_t              c2_reg;
    logic              s2_valid_reg;

    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            h_next[i][0] = {33'd0, pp_reg[i][0]} + {1'b0, pp_reg[i][1], 32'd0};
            h_next[i][1] = {33'd0, pp_reg[i][2]} + {1'b0, pp_reg[i][3], 32'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg   <= h_next;
            sum_reg <= ta_reg + tb_reg;
            c2_reg  <= c1_reg;
        end
    end

    // ---------------- stage 3: row sums, sign-magnitude result -------------
    logic [191:0]      row_next [LIMBS];
    logic [191:0]      row_reg  [LIMBS];
    logic [WORD_W-1:0] mag_tc, alt_next, alt3_reg;
    ctl_t              c3_reg;
    logic              s3_valid_reg;

    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            row_next[i] = {95'd0, h_reg[i][0]} + {31'd0, h_reg[i][1], 64'd0};
        end
        mag_tc = sum_reg[127] ? (~sum_reg + 128'd1) : sum_reg;
        case (c2_reg.cmd) inside
            CMD_ADD, CMD_SUB: alt_next = {mag_tc[127] | sum_reg[127], mag_tc[126:0]};
            CMD_NEG:          alt_next = {~c2_reg.a[127], c2_reg.a[126:0]};
            CMD_ABS:          alt_next = {1'b0, c2_reg.a[126:0]};
            default:          alt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg  <= row_next;
            alt3_reg <= alt_next;
            c3_reg   <= c2_reg;
        end
    end

    // ---------------- stage 4: pair rows ----------------------------------
    logic [223:0]      t0_reg, t1_reg;
    logic [WORD_W-1:0] alt4_reg;
    ctl_t              c4_reg;
    logic              s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg   <= {32'd0, row_reg[0]} + {row_reg[1], 32'd0};
            t1_reg   <= {32'd0, row_reg[2]} + {row_reg[3], 32'd0};
            alt4_reg <= alt3_reg;
            c4_reg   <= c3_reg;
        end
    end

    // ---------------- stage 5: full product into the divider --------------
    logic [255:0] prod;
    div_pay_t     d0_next;

    always_comb
    begin
        prod          = {32'd0, t0_reg} + {t1_reg[191:0], 64'd0};
        d0_next.rem   = '0;
        d0_next.nq    = prod[NUM_W-1:0];
        d0_next.d     = c4_reg.d;
        d0_next.use_q = (c4_reg.cmd == CMD_MUL) || (c4_reg.cmd == CMD_DIV);
        d0_next.sgn   = c4_reg.sgn;
        d0_next.dz    = c4_reg.dz;
        d0_next.alt   = alt4_reg;
    end

    // ---------------- divider array: one quotient bit per stage -----------
    div_pay_t div_reg   [DIV_STEPS];
    div_pay_t div_next  [DIV_STEPS];
    logic     dv_reg    [DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en)
            dv_reg[0] <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg[0] <= d0_next;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [MAG_W:0] rem2, diff;
        logic           ge;

        // Shift in one numerator bit, subtract the divisor when it fits
        always_comb
        begin
            rem2        = {div_reg[k].rem, div_reg[k].nq[NUM_W-1]};
            diff        = rem2 - {1'b0, div_reg[k].d};
            ge          = rem2 >= {1'b0, div_reg[k].d};
            div_next[k]     = div_reg[k];
            div_next[k].rem = ge ? diff[MAG_W-1:0] : rem2[MAG_W-1:0];
            div_next[k].nq  = {div_reg[k].nq[NUM_W-2:0], ge};
        end

        if (k < DIV_STEPS - 1)
        begin : g_next
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[k+1] <= 1'b0;
                else if (en)
                    dv_reg[k+1] <= dv_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    div_reg[k+1] <= div_next[k];
            end
        end
    end

    // ---------------- output register -------------------------------------
    div_pay_t          fin;
    logic [WORD_W-1:0] res_next;
    logic              out_valid_reg;
    logic [127:0]      out_data_reg;
    logic              out_dz_reg;

    always_comb
    begin
        fin = div_next[DIV_STEPS-1];
        if (fin.dz)
            res_next = '0;
        else if (fin.use_q)
            res_next = {fin.nq[127] | fin.sgn, fin.nq[126:0]};
        else
            res_next = fin.alt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_reg[DIV_STEPS-1];
    end

    // Upper half goes out in the low bits, lower half above it
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {res_next[63:0], res_next[127:64]};
            out_dz_reg   <= fin.dz;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_dz_reg;

    // ---------------- assertions ------------------------------------------
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("divide-by-zero result not zero");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready out of step with output stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> s1_valid_reg)
        else $error("accepted item missing from first stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_reg[0]) && $stable(s4_valid_reg))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== bench/decimal_fixed_point_alu_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// decimal_fixed_point_alu_tb
// Self-checking bench for the decimal fixed-point arithmetic unit. A directed
// table covers the operand extremes, every command and the sign and divisor
// corner cases. Random operations follow, with random idling on both sides,
// one long output stall and one drain pause. Every result is checked against
// the table's own value or an in-bench predictor on wide vector arithmetic.
// ============================================================================
`default_nettype none

module decimal_fixed_point_alu_tb
    import dfpa_pkg::*;
();

    localparam int RANDOM_ITEMS = 1950;
    localparam int PIPE_DEPTH   = 259;

    typedef struct packed {
        logic [127:0] res;
        logic         dz;
    } alu_result_t;

    typedef struct {
        logic [2:0]   cmd;
        logic [127:0] a;
        logic [127:0] b;
        bit           typed;
        alu_result_t  want;
    } vector_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    alu_result_t  pending_results[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           items_sent = 0;
    bit           calm = 1'b0;
    bit           stall_request = 1'b0;
    int           stall_left = 0;

    decimal_fixed_point_alu DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Sign-magnitude to two's complement
    function automatic logic [127:0] to_twos(logic [127:0] x);
        logic [127:0] m;
        begin
            m = {1'b0, x[126:0]};
            return x[127] ? -m : m;
        end
    endfunction

    // Work out the result of one operation on wide vectors
    function automatic alu_result_t compute_alu(logic [2:0] cmd, logic [127:0] a,
                                                logic [127:0] b);
        logic [127:0] am;
        logic [127:0] bm;
        logic [127:0] sum;
        logic [255:0] wide;
        logic         sgn;
        alu_result_t  r;
        begin
            am  = {1'b0, a[126:0]};
            bm  = {1'b0, b[126:0]};
            sgn = a[127] ^ b[127];
            r   = '0;
            case (cmd) inside
                CMD_ADD, CMD_SUB:
                begin
                    sum = (cmd == CMD_ADD) ? to_twos(a) + to_twos(b)
                                           : to_twos(a) - to_twos(b);
                    if (sum[127])
                    begin
                        r.res = -sum;
                        r.res[127] = 1'b1;
                    end
                    else
                        r.res = sum;
                end
                CMD_MUL:
                begin
                    wide = ({128'd0, am} * {128'd0, bm}) / {192'd0, DEC_ONE};
                    r.res = wide[127:0];
                    r.res[127] = r.res[127] | sgn;
                end
                CMD_DIV:
                begin
                    if (bm == '0)
                        r.dz = 1'b1;
                    else
                    begin
                        wide = ({128'd0, am} * {192'd0, DEC_ONE}) / {128'd0, bm};
                        r.res = wide[127:0];
                        r.res[127] = r.res[127] | sgn;
                    end
                end
                CMD_NEG: r.res = {~a[127], a[126:0]};
                CMD_ABS: r.res = am;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Random operand: zero, small, whole units, full width or the maximum
    function automatic logic [127:0] pick_operand();
        logic [126:0] mag;
        begin
            case ($urandom_range(0, 9)) inside
                0:       mag = '0;
                1:       mag = '1;
                2, 3:    mag = {63'd0, $urandom(), $urandom()};
                4, 5:    mag = 127'($urandom_range(0, 1000)) * DEC_ONE;
                6:       mag = 127'($urandom_range(1, 20));
                default: mag = 127'({$urandom(), $urandom(), $urandom(), $urandom()});
            endcase
            return {$urandom_range(0, 1) == 1, mag};
        end
    endfunction

    // Offer one item, idle at random first, and hold until it is accepted
    task automatic send_item(logic [2:0] cmd, logic [127:0] a, logic [127:0] b,
                             bit typed, alu_result_t want);
        begin
            if (!calm && $urandom_range(0, 99) < 13)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= cmd;
            s_axis_tdata  <= {b[63:0], b[127:64], a[63:0], a[127:64]};
            do @(posedge clk); while (!s_axis_tready);
            pending_results.push_back(typed ? want : compute_alu(cmd, a, b));
            items_sent++;
        end
    endtask

    // Check each result item and pick the next ready value
    initial
    begin
        alu_result_t want;
        alu_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.res = {m_axis_tdata[63:0], m_axis_tdata[127:64]};
                got.dz  = m_axis_tuser[0];
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h dz=%b", got.res, got.dz);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %h dz=%b, got %h dz=%b",
                                     results_seen, want.res, want.dz, got.res, got.dz);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_request)
            begin
                stall_request = 1'b0;
                stall_left    = 3 * PIPE_DEPTH;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || !rst_n || ($urandom_range(0, 99) >= 13);
        end
    end

    // Bound the run
    initial
    begin
        #2ms;
        $display("decimal_fixed_point_alu test failed");
        $finish;
    end

    // Directed table, then random operations
    initial
    begin
        vector_row_t  rows[$];
        vector_row_t  row;
        logic [127:0] neg_half;
        logic [2:0]   cmd;
        alu_result_t  none;

        none = '0;
        neg_half = {1'b1, 1'b1, 126'd0};
        rows = '{
            '{CMD_ADD, '0, '0, 1, '{'0, 1'b0}},
            '{CMD_NEG, '0, '0, 1, '{{1'b1, 127'd0}, 1'b0}},
            '{CMD_ABS, '1, '0, 1, '{{1'b0, {127{1'b1}}}, 1'b0}},
            '{CMD_DIV, '1, '0, 1, '{'0, 1'b1}},
            '{CMD_DIV, 128'd5, {1'b1, 127'd0}, 1, '{'0, 1'b1}},
            '{3'd6, '1, '1, 1, '{'0, 1'b0}},
            '{3'd7, '1, '1, 1, '{'0, 1'b0}},
            '{CMD_ADD, neg_half, neg_half, 1, '{{1'b1, 127'd0}, 1'b0}},
            '{CMD_MUL, 128'(DEC_ONE), 128'(DEC_ONE), 1, '{128'(DEC_ONE), 1'b0}},
            '{CMD_DIV, 128'(DEC_ONE), 128'(DEC_ONE), 1, '{128'(DEC_ONE), 1'b0}},
            '{CMD_ADD, {1'b0, {127{1'b1}}}, {1'b0, {127{1'b1}}}, 0, none},
            '{CMD_ADD, '1, '1, 0, none},
            '{CMD_SUB, '0, '1, 0, none},
            '{CMD_SUB, 128'd7, 128'd7, 0, none},
            '{CMD_SUB, {1'b1, 127'd3}, {1'b0, 127'd9}, 0, none},
            '{CMD_MUL, '1, '1, 0, none},
            '{CMD_MUL, {1'b1, 127'd0}, 128'd5, 0, none},
            '{CMD_DIV, '1, 128'd1, 0, none},
            '{CMD_DIV, 128'd1, '1, 0, none},
            '{CMD_NEG, '1, '0, 0, none},
            '{CMD_ABS, '0, '1, 0, none}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the directed table
        foreach (rows[i])
        begin
            row = rows[i];
            send_item(row.cmd, row.a, row.b, row.typed, row.want);
        end

        // Random operations with a stall, a drain pause and a calm stretch
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 500)
                stall_request = 1'b1;
            if (n == 1100)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
            end
            calm = (n >= 1300 && n < 1550);
            cmd = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            send_item(cmd, pick_operand(), pick_operand(), 0, none);
        end
        s_axis_tvalid <= 1'b0;

        // Drain and let the pipeline settle
        while (pending_results.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);

        $display("Sent %0d items over all commands; checked %0d results, %0d mismatches.",
                 items_sent, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("decimal_fixed_point_alu test passed");
        else
            $display("decimal_fixed_point_alu test failed");
        $finish;
    end

endmodule

`default_nettype wire
